@@ src/mexp_pkg.sv @@
// Package for the modular exponentiation block: field widths, the reset modulus,
// the sequencer state type and the control structs of the shared multiplier.
// Has no dependencies; every other file refers to it by scoped names.
package mexp_pkg;

   localparam int BASE_WIDTH      = 32;
   localparam int EXP_WIDTH       = 32;
   localparam int RESULT_WIDTH    = 31;
   localparam int REQ_TDATA_WIDTH = 64;
   localparam int RSP_TDATA_WIDTH = 32;
   localparam int CSR_DATA_WIDTH  = 31;
   // The bit counter of the multiplier must hold BASE_WIDTH itself.
   localparam int CNT_WIDTH       = $clog2(BASE_WIDTH + 1);

   localparam logic [RESULT_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL_ACC,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic wide;
   } mm_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

@@ src/mexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of x per cycle.
// Depends on mexp_pkg for widths and the command and status structs.
module mexp_mulmod #(
   parameter int MOD_BITS = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mexp_pkg::mm_cmd_type              cmd,
   input  logic [mexp_pkg::BASE_WIDTH-1:0]   x_i,
   input  logic [MOD_BITS-1:0]               y_i,
   input  logic [MOD_BITS-1:0]               m_i,
   output mexp_pkg::mm_status_type           status,
   output logic [MOD_BITS-1:0]               result
);

   localparam int SW = MOD_BITS + 3;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [mexp_pkg::CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [mexp_pkg::BASE_WIDTH-1:0]     x_ff, x_in;
   logic [MOD_BITS-1:0]                 r_ff, r_in;
   logic [MOD_BITS-1:0]                 m_ff, m_in;
   logic signed [SW-1:0]                ky_ff, ky_in;
   logic signed [SW-1:0]                ky1_ff, ky1_in;
   logic signed [SW-1:0]                ky2_ff, ky2_in;
   logic signed [SW-1:0]                km1_ff, km1_in;
   logic signed [SW-1:0]                km2_ff, km2_in;

   logic                                x_bit;
   logic signed [SW-1:0]                twice;
   logic signed [SW-1:0]                s0, s1, s2;
   logic [MOD_BITS-1:0]                 r_step;

   // The partial remainder 2r + bit*y stays below 3m, so the three candidates
   // t, t - m and t - 2m are formed side by side and the smallest one that is
   // not negative is kept.
   always_comb begin
      x_bit = x_ff[mexp_pkg::BASE_WIDTH-1];
      twice = $signed({2'b00, r_ff, 1'b0});
      s0    = twice + (x_bit ? ky_ff : '0);
      s1    = twice + (x_bit ? ky1_ff : km1_ff);
      s2    = twice + (x_bit ? ky2_ff : km2_ff);
      if (!s2[SW-1]) begin
         r_step = s2[MOD_BITS-1:0];
      end else if (!s1[SW-1]) begin
         r_step = s1[MOD_BITS-1:0];
      end else begin
         r_step = s0[MOD_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      m_in    = m_ff;
      ky_in   = ky_ff;
      ky1_in  = ky1_ff;
      ky2_in  = ky2_ff;
      km1_in  = km1_ff;
      km2_in  = km2_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.wide ? mexp_pkg::CNT_WIDTH'(mexp_pkg::BASE_WIDTH)
                            : mexp_pkg::CNT_WIDTH'(MOD_BITS);
         x_in    = x_i;
         r_in    = '0;
         m_in    = m_i;
         ky_in   = $signed({3'b000, y_i});
         ky1_in  = $signed({3'b000, y_i}) - $signed({3'b000, m_i});
         ky2_in  = $signed({3'b000, y_i}) - $signed({2'b00, m_i, 1'b0});
         km1_in  = -$signed({3'b000, m_i});
         km2_in  = -$signed({2'b00, m_i, 1'b0});
      end else if (busy_ff) begin
         x_in   = {x_ff[mexp_pkg::BASE_WIDTH-2:0], 1'b0};
         r_in   = r_step;
         cnt_in = cnt_ff - mexp_pkg::CNT_WIDTH'(1);
         if (cnt_ff == mexp_pkg::CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      m_ff   <= m_in;
      ky_ff  <= ky_in;
      ky1_ff <= ky1_in;
      ky2_ff <= ky2_in;
      km1_ff <= km1_in;
      km2_ff <= km2_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier reports done while still busy");

   a_busy_count : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("multiplier busy with an empty bit count");

   a_done_reduced : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (r_ff < m_ff))
      else $error("multiplier result not reduced below the modulus");

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("multiplier started while busy");

endmodule

@@ src/modular_exponentiation.sv @@
// Sequence: the base is first reduced by a wide multiplier pass, then each set exponent bit
// below the top one costs a multiply and a square, each clear one below the top set bit a square
// only, and the top set bit a multiply only. A zero modulus skips the multiplier entirely.
// Throughput: one transaction at a time, set by the single interleaved multiplier taking one
// bit per cycle; a new request is taken while the previous result waits on the output.
// Reset: synchronous; clears control and sets the modulus to 1000000007.
module modular_exponentiation #(
   parameter int EXP_BITS = 32,
   parameter int MOD_BITS = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // req_tdata: base_value [31:0], exponent [63:32]
   input  logic [mexp_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // rsp_tdata: power_result [30:0], zero [31]
   output logic [mexp_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mexp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam logic [mexp_pkg::EXP_WIDTH-1:0] EXP_MASK =
      (EXP_BITS >= mexp_pkg::EXP_WIDTH) ? {mexp_pkg::EXP_WIDTH{1'b1}}
         : mexp_pkg::EXP_WIDTH'((64'd1 << EXP_BITS) - 64'd1);
   localparam int PAD_BITS = mexp_pkg::BASE_WIDTH - MOD_BITS;

   mexp_pkg::state_type                state_ff, state_in;
   logic [MOD_BITS-1:0]                mod_ff, mod_in;
   logic [MOD_BITS-1:0]                mod_item_ff, mod_item_in;
   logic [MOD_BITS-1:0]                acc_ff, acc_in;
   logic [MOD_BITS-1:0]                b_ff, b_in;
   logic [mexp_pkg::EXP_WIDTH-1:0]     exp_ff, exp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0]                rsp_data_ff, rsp_data_in;

   mexp_pkg::mm_cmd_type               mm_cmd;
   mexp_pkg::mm_status_type            mm_status;
   logic [mexp_pkg::BASE_WIDTH-1:0]    op_x;
   logic [MOD_BITS-1:0]                op_y;
   logic [MOD_BITS-1:0]                op_m;
   logic [MOD_BITS-1:0]                mm_result;
   logic                               req_accept;
   logic                               rsp_free;
   logic [mexp_pkg::EXP_WIDTH-1:0]     exp_shifted;

   assign req_accept  = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign exp_shifted = {1'b0, exp_ff[mexp_pkg::EXP_WIDTH-1:1]};
   assign csr_ready   = 1'b1;

   mexp_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mm_cmd),
      .x_i    (op_x),
      .y_i    (op_y),
      .m_i    (op_m),
      .status (mm_status),
      .result (mm_result)
   );

   always_comb begin
      mod_in = mod_ff;
      if (csr_valid && csr_ready) begin
         mod_in = csr_data[MOD_BITS-1:0];
      end
   end

   // Right-to-left square-and-multiply: a set low exponent bit multiplies the
   // accumulator by the running base, then the base is squared unless no set
   // bits remain.
   always_comb begin
      state_in     = state_ff;
      mod_item_in  = mod_item_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      mm_cmd.start = 1'b0;
      mm_cmd.wide  = 1'b0;
      op_x         = {b_ff, {PAD_BITS{1'b0}}};
      op_y         = b_ff;
      op_m         = mod_item_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            op_x       = req_tdata[mexp_pkg::BASE_WIDTH-1:0];
            op_y       = MOD_BITS'(1);
            op_m       = mod_ff;
            if (req_accept) begin
               mod_item_in = mod_ff;
               exp_in      = req_tdata[mexp_pkg::REQ_TDATA_WIDTH-1:mexp_pkg::BASE_WIDTH]
                             & EXP_MASK;
               if (mod_ff == '0) begin
                  acc_in   = '0;
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  acc_in       = MOD_BITS'(mod_ff != MOD_BITS'(1));
                  mm_cmd.start = 1'b1;
                  mm_cmd.wide  = 1'b1;
                  state_in     = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mm_status.done) begin
               b_in     = mm_result;
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = mexp_pkg::ST_FINISH;
            end else if (exp_ff[0]) begin
               op_x         = {acc_ff, {PAD_BITS{1'b0}}};
               mm_cmd.start = 1'b1;
               state_in     = mexp_pkg::ST_MUL_ACC;
            end else begin
               // A clear bit with set bits above it: square only.
               mm_cmd.start = 1'b1;
               exp_in       = exp_shifted;
               state_in     = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_MUL_ACC: begin
            if (mm_status.done) begin
               acc_in = mm_result;
               exp_in = exp_shifted;
               if (exp_shifted == '0) begin
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  mm_cmd.start = 1'b1;
                  state_in     = mexp_pkg::ST_SQUARE;
               end
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (mm_status.done) begin
               b_in     = mm_result;
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         mod_ff       <= mexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_item_ff <= mod_item_in;
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mexp_pkg::RSP_TDATA_WIDTH - MOD_BITS){1'b0}}, rsp_data_ff};

   a_acc_reduced : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == mexp_pkg::ST_STEP) || (state_ff == mexp_pkg::ST_MUL_ACC)
         || (state_ff == mexp_pkg::ST_SQUARE)) |-> (acc_ff < mod_item_ff))
      else $error("accumulator not reduced below the modulus");

   a_base_reduced : assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_STEP) |-> (b_ff < mod_item_ff))
      else $error("running base not reduced below the modulus");

   a_done_expected : assert property (@(posedge clock) disable iff (reset)
      mm_status.done |-> ((state_ff == mexp_pkg::ST_REDUCE)
         || (state_ff == mexp_pkg::ST_MUL_ACC) || (state_ff == mexp_pkg::ST_SQUARE)))
      else $error("multiplier finished in a state that does not wait for it");

   a_start_free : assert property (@(posedge clock) disable iff (reset)
      mm_cmd.start |-> !mm_status.busy)
      else $error("multiplier started while a product is under way");

endmodule
